### design/tcs_pkg.sv
// Shared types and constants for the TCP option cookie scrubber.
// No dependencies; imported by the top level, tcs_parser and tcs_outq.
package tcs_pkg;

  localparam int unsigned MAX_OPTION_BYTES_DEF = 40;
  localparam logic [7:0]  TARGET_KIND_RST      = 8'd34;
  localparam logic [7:0]  NOP_BYTE             = 8'h01;
  localparam logic [7:0]  MIN_OPTION_LEN       = 8'd2;
  localparam int unsigned OUTQ_DEPTH           = 4;

  typedef enum logic [1:0] {
    MODE_KIND,
    MODE_HOLD,
    MODE_BODY,
    MODE_PASS
  } mode_t;

  typedef struct packed {
    logic [7:0] opt_byte;
    logic       first_byte;
    logic [5:0] area_length;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_out;
    logic       cookie_removed;
  } res_t;

  // Up to two result beats per parsed byte; slot 1 is used only with slot 0.
  typedef struct packed {
    logic v0;
    logic v1;
    res_t r0;
    res_t r1;
  } push_t;

endpackage

### design/tcs_in_if.sv
// Input channel of the cookie scrubber: valid/ready plus one option byte.
// Stand-alone interface, no dependencies.
interface tcs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] opt_byte;
  logic       first_byte;
  logic [5:0] area_length;

  modport source (output valid, output opt_byte, output first_byte, output area_length,
                  input ready);
  modport sink   (input valid, input opt_byte, input first_byte, input area_length,
                  output ready);
endinterface

### design/tcs_out_if.sv
// Result channel of the cookie scrubber: valid/ready plus one output byte.
// Stand-alone interface, no dependencies.
interface tcs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_out;
  logic       cookie_removed;

  modport source (output valid, output out_byte, output last_out, output cookie_removed,
                  input ready);
  modport sink   (input valid, input out_byte, input last_out, input cookie_removed,
                  output ready);
endinterface

### design/tcp_option_cookie_scrubber.sv
// TCP option cookie scrubber, top level.
// in_ch (sink) takes one option byte per beat with first_byte/area_length;
// out_ch (source) gives zero, one or two result beats per input beat, in
// order, with last_out and cookie_removed on the final byte of the area.
// cfg_we/cfg_wdata write target_kind (reset 34); write only while idle.
// Path: an accepted byte goes into the input register, is parsed from there,
// and its result beats are written into the queue that drives out_ch. Kind
// bytes are held until their length byte arrives and show up one byte later.
// Throughput: one input beat per cycle while out_ch stays ready; a
// four-entry result queue absorbs the two-beat burst after each length byte,
// and the parse stage advances only while the queue has room for two beats.
// A stalled receiver fills the queue, then the input register, then
// in_ch.ready drops; nothing is lost. Reset empties input register and
// queue and puts the walker back to expecting a kind byte.
// Depends on tcs_pkg, tcs_in_if, tcs_out_if, tcs_parser, tcs_outq.
module tcp_option_cookie_scrubber #(
  parameter int unsigned MAX_OPTION_BYTES = tcs_pkg::MAX_OPTION_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  tcs_in_if.sink     in_ch,
  tcs_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);
  import tcs_pkg::*;

  in_item_t   in_r;
  logic       in_vld_r;
  logic [7:0] target_r;
  logic       room, adv, in_fire;
  push_t      push;

  assign adv         = in_vld_r && room;
  assign in_ch.ready = !in_vld_r || adv;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      target_r <= TARGET_KIND_RST;
    end else begin
      if (in_fire) in_vld_r <= 1'b1;
      else if (adv) in_vld_r <= 1'b0;
      if (cfg_we) target_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_r <= '{opt_byte: in_ch.opt_byte, first_byte: in_ch.first_byte,
                area_length: in_ch.area_length};
    end
  end

  tcs_parser #(.MAX_BYTES(MAX_OPTION_BYTES)) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (adv),
    .item        (in_r),
    .target_kind (target_r),
    .push        (push)
  );

  tcs_outq u_outq (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .room   (room),
    .out_ch (out_ch)
  );

endmodule

### design/tcs_parser.sv
// Option walker: holds the parse state and turns one registered byte into
// zero, one or two result beats. Depends on tcs_pkg.
module tcs_parser #(
  parameter int unsigned MAX_BYTES = tcs_pkg::MAX_OPTION_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  tcs_pkg::in_item_t item,
  input  logic [7:0]       target_kind,
  output tcs_pkg::push_t   push
);
  import tcs_pkg::*;

  localparam logic [5:0] MAX_W = 6'(MAX_BYTES);

  mode_t      mode_r, mode_nxt, mode_e;
  logic [5:0] pos_r, pos_nxt, pos_e;
  logic [5:0] size_r, size_nxt, size_e;
  logic [7:0] held_r, held_nxt, held_e;
  logic [5:0] rem_r, rem_nxt, rem_e, rem_dec;
  logic       scrub_r, scrub_nxt, scrub_e;
  logic       found_r, found_nxt, found_e;

  logic [7:0] b;
  logic [5:0] alen_sat;
  logic       active, last, single, bad_len, hit;
  logic [8:0] end_pos;

  assign b        = item.opt_byte;
  assign alen_sat = (item.area_length > MAX_W) ? MAX_W : item.area_length;

  // A first byte restarts the walk before the byte itself is looked at.
  assign mode_e  = item.first_byte ? MODE_KIND : mode_r;
  assign pos_e   = item.first_byte ? 6'd0 : pos_r;
  assign size_e  = item.first_byte ? alen_sat : size_r;
  assign held_e  = item.first_byte ? 8'd0 : held_r;
  assign rem_e   = item.first_byte ? 6'd0 : rem_r;
  assign scrub_e = item.first_byte ? 1'b0 : scrub_r;
  assign found_e = item.first_byte ? 1'b0 : found_r;

  assign active  = pos_e < size_e;
  assign last    = ({1'b0, pos_e} + 7'd1) == {1'b0, size_e};
  assign single  = (b == 8'd0) || (b == NOP_BYTE);
  // kind byte sat one place back; option must end inside the area
  assign end_pos = {3'b0, pos_e} - 9'd1 + {1'b0, b};
  assign bad_len = (b < MIN_OPTION_LEN) || (end_pos > {3'b0, size_e});
  assign hit     = held_e == target_kind;
  assign rem_dec = rem_e - {5'd0, (rem_e != 6'd0)};

  // next state
  always_comb begin
    mode_nxt  = mode_e;
    pos_nxt   = pos_e;
    size_nxt  = size_e;
    held_nxt  = held_e;
    rem_nxt   = rem_e;
    scrub_nxt = scrub_e;
    found_nxt = found_e;
    if (active) begin
      pos_nxt = pos_e + 6'd1;
      unique case (mode_e)
        MODE_KIND: begin
          if (!single) begin
            if (last) begin
              mode_nxt = MODE_PASS;
            end else begin
              held_nxt = b;
              mode_nxt = MODE_HOLD;
            end
          end
        end
        MODE_HOLD: begin
          if (bad_len) begin
            mode_nxt = MODE_PASS;
          end else begin
            rem_nxt   = 6'(b - MIN_OPTION_LEN);
            scrub_nxt = hit;
            if (hit) found_nxt = 1'b1;
            mode_nxt  = (b == MIN_OPTION_LEN) ? MODE_KIND : MODE_BODY;
          end
        end
        MODE_BODY: begin
          rem_nxt = rem_dec;
          if (rem_dec == 6'd0) mode_nxt = MODE_KIND;
        end
        MODE_PASS: begin
        end
        default: begin
        end
      endcase
    end
  end

  // result beats
  always_comb begin
    push = '0;
    if (fire && active) begin
      unique case (mode_e)
        MODE_KIND: begin
          if (single || last) begin
            push.v0 = 1'b1;
            push.r0 = '{out_byte: b, last_out: last, cookie_removed: last && found_e};
          end
        end
        MODE_HOLD: begin
          push.v0 = 1'b1;
          push.v1 = 1'b1;
          if (!bad_len && hit) begin
            push.r0 = '{out_byte: NOP_BYTE, last_out: 1'b0, cookie_removed: 1'b0};
            push.r1 = '{out_byte: NOP_BYTE, last_out: last, cookie_removed: last};
          end else begin
            push.r0 = '{out_byte: held_e, last_out: 1'b0, cookie_removed: 1'b0};
            push.r1 = '{out_byte: b, last_out: last, cookie_removed: last && found_e};
          end
        end
        MODE_BODY: begin
          push.v0 = 1'b1;
          push.r0 = '{out_byte: scrub_e ? NOP_BYTE : b, last_out: last,
                      cookie_removed: last && found_e};
        end
        MODE_PASS: begin
          push.v0 = 1'b1;
          push.r0 = '{out_byte: b, last_out: last, cookie_removed: last && found_e};
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_KIND;
      pos_r   <= '0;
      size_r  <= '0;
      held_r  <= '0;
      rem_r   <= '0;
      scrub_r <= 1'b0;
      found_r <= 1'b0;
    end else if (fire) begin
      mode_r  <= mode_nxt;
      pos_r   <= pos_nxt;
      size_r  <= size_nxt;
      held_r  <= held_nxt;
      rem_r   <= rem_nxt;
      scrub_r <= scrub_nxt;
      found_r <= found_nxt;
    end
  end

`ifndef SYNTHESIS
  a_hold_has_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_HOLD) |-> (pos_r != 6'd0))
    else $error("holding a kind byte at area position zero");
  a_pair_from_hold: assert property (@(posedge clk) disable iff (!rst_n)
    push.v1 |-> (mode_e == MODE_HOLD))
    else $error("two beats outside the length check");
  a_flag_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (push.r1.cookie_removed && push.v1) |-> push.r1.last_out)
    else $error("cookie flag on a non-final beat");
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= size_r)
    else $error("byte position ran past the area");
`endif

endmodule

### design/tcs_outq.sv
// Small result queue: takes up to two beats a cycle, gives one beat a cycle while out_ch is ready.
// Depends on tcs_pkg and tcs_out_if.
module tcs_outq (
  input  logic           clk,
  input  logic           rst_n,
  input  tcs_pkg::push_t push,
  output logic           room,
  tcs_out_if.source      out_ch
);
  import tcs_pkg::*;

  localparam int unsigned DEPTH = OUTQ_DEPTH;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  res_t          mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r, wp1;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [1:0]    n_push;
  logic          pop;

  assign pop    = out_ch.valid && out_ch.ready;
  assign n_push = {1'b0, push.v0} + {1'b0, push.v1};
  assign wp1    = wp_r + AW'(1);
  assign cnt_nxt = cnt_r + CW'(n_push) - CW'(pop);
  // room for a two-beat burst, decided from registers only
  assign room   = cnt_r <= CW'(DEPTH - 2);

  assign out_ch.valid          = cnt_r != '0;
  assign out_ch.out_byte       = mem_r[rp_r].out_byte;
  assign out_ch.last_out       = mem_r[rp_r].last_out;
  assign out_ch.cookie_removed = mem_r[rp_r].cookie_removed;

  always_ff @(posedge clk) begin
    if (push.v0) mem_r[wp_r] <= push.r0;
    if (push.v1) mem_r[wp1]  <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + AW'(n_push);
      if (pop) rp_r <= rp_r + AW'(1);
      cnt_r <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("result queue overflow");
  a_slot_order: assert property (@(posedge clk) disable iff (!rst_n)
    push.v1 |-> push.v0)
    else $error("second beat without first");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push.v0 && !room) |-> 1'b0)
    else $error("push into a queue without room");
`endif

endmodule
